FILE: rtl/core/acl_pkg.sv
// ----------------------------------------------------------------------------
// acl_pkg
// Shared types, character codes and keyword tables for the command line parser.
// ----------------------------------------------------------------------------
package acl_pkg;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam int NUM_FIELDS = 12;
   localparam int NUM_VALUES = 7;

   localparam logic [4:0] KW_ROOT = 5'd0;
   localparam logic [4:0] KW_DEAD = 5'd30;
   localparam logic [4:0] WC_MAX  = 5'd31;

   typedef enum logic [3:0] {
      CMD_EMPTY   = 4'd0,
      CMD_DAT     = 4'd1,
      CMD_D       = 4'd2,
      CMD_DLOW    = 4'd3,
      CMD_START   = 4'd4,
      CMD_STOP    = 4'd5,
      CMD_MOT     = 4'd6,
      CMD_R       = 4'd7,
      CMD_C       = 4'd8,
      CMD_L       = 4'd9,
      CMD_THRESH  = 4'd10,
      CMD_SENSI   = 4'd11,
      CMD_E       = 4'd12,
      CMD_UNKNOWN = 4'd13
   } cmd_type;

   typedef logic [NUM_FIELDS-1:0][15:0] field_array_type;
   typedef logic [NUM_VALUES-1:0][15:0] value_array_type;

   typedef struct packed {
      logic [4:0] word_count;
      logic [4:0] keyword;
      logic       fields_ok;
   } line_info_type;

   typedef struct packed {
      cmd_type         command;
      logic            accepted;
      logic [5:0]      buttons;
      value_array_type values;
      logic            running;
      logic [31:0]     link_errors;
   } result_type;

   function automatic logic [4:0] kw_next(input logic [4:0] s, input logic [7:0] c);
      logic [4:0] n;
      begin
         n = KW_DEAD;
         case (s)
            5'd0: begin
               case (c)
                  "D": n = 5'd1;
                  "d": n = 5'd4;
                  "s": n = 5'd5;
                  "M": n = 5'd12;
                  "R": n = 5'd15;
                  "C": n = 5'd16;
                  "L": n = 5'd17;
                  "T": n = 5'd18;
                  "S": n = 5'd24;
                  "E": n = 5'd29;
                  default: n = KW_DEAD;
               endcase
            end
            5'd1:  if (c == "A") n = 5'd2;
            5'd2:  if (c == "T") n = 5'd3;
            5'd5:  if (c == "t") n = 5'd6;
            5'd6: begin
               if (c == "a") n = 5'd7;
               else if (c == "o") n = 5'd10;
            end
            5'd7:  if (c == "r") n = 5'd8;
            5'd8:  if (c == "t") n = 5'd9;
            5'd10: if (c == "p") n = 5'd11;
            5'd12: if (c == "O") n = 5'd13;
            5'd13: if (c == "T") n = 5'd14;
            5'd18: if (c == "H") n = 5'd19;
            5'd19: if (c == "R") n = 5'd20;
            5'd20: if (c == "E") n = 5'd21;
            5'd21: if (c == "S") n = 5'd22;
            5'd22: if (c == "H") n = 5'd23;
            5'd24: if (c == "E") n = 5'd25;
            5'd25: if (c == "N") n = 5'd26;
            5'd26: if (c == "S") n = 5'd27;
            5'd27: if (c == "I") n = 5'd28;
            default: n = KW_DEAD;
         endcase
         return n;
      end
   endfunction

   function automatic cmd_type kw_term(input logic [4:0] s);
      cmd_type t;
      begin
         case (s)
            5'd1:    t = CMD_D;
            5'd3:    t = CMD_DAT;
            5'd4:    t = CMD_DLOW;
            5'd9:    t = CMD_START;
            5'd11:   t = CMD_STOP;
            5'd14:   t = CMD_MOT;
            5'd15:   t = CMD_R;
            5'd16:   t = CMD_C;
            5'd17:   t = CMD_L;
            5'd23:   t = CMD_THRESH;
            5'd28:   t = CMD_SENSI;
            5'd29:   t = CMD_E;
            default: t = CMD_UNKNOWN;
         endcase
         return t;
      end
   endfunction

endpackage

FILE: rtl/core/acl_parse.sv
// ----------------------------------------------------------------------------
// acl_parse
// Per-byte line tracker: word splitting, keyword walk, decimal field check.
// ----------------------------------------------------------------------------
module acl_parse #(
   parameter int LINE_MAX = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               rx_byte,
   output acl_pkg::line_info_type   info,
   output acl_pkg::field_array_type fields
);

   localparam int LW = $clog2(LINE_MAX);
   localparam logic [LW:0] LEN_LIMIT = (LW+1)'(LINE_MAX - 1);

   typedef enum logic [1:0] {PH_WS, PH_SIGN, PH_DIGITS, PH_BAD} phase_type;

   logic [LW-1:0]            len_ff, len_in;
   logic [4:0]               wc_ff, wc_in;
   logic                     inw_ff, inw_in;
   logic                     nul_ff, nul_in;
   logic [4:0]               kw_ff, kw_in;
   phase_type                ph_ff, ph_in;
   logic [31:0]              acc_ff, acc_in;
   logic                     neg_ff, neg_in;
   logic                     ovf_ff, ovf_in;
   logic                     fv_ff, fv_in;
   acl_pkg::field_array_type pend_ff, pend_in;

   logic [LW:0]              len_inc;
   logic [4:0]               fin_idx;
   logic                     fin_ok, fin_word;
   logic [15:0]              num_val;
   acl_pkg::field_array_type pend_fin;
   logic                     fv_fin;
   logic [4:0]               wc_new;
   phase_type                ph;
   logic [31:0]              acc;
   logic                     neg, ovf;
   logic                     is_digit, is_space;
   logic [35:0]              nv;

   always_comb begin
      if (neg_ff) begin
         num_val = ovf_ff ? 16'h0000 : 16'(32'd0 - acc_ff);
      end else if (ovf_ff || acc_ff > 32'h7FFF_FFFF) begin
         num_val = 16'hFFFF;
      end else begin
         num_val = acc_ff[15:0];
      end
   end

   always_comb begin
      fin_idx  = wc_ff - 5'd2;
      fin_ok   = (ph_ff == PH_DIGITS);
      fin_word = inw_ff && (wc_ff >= 5'd2);
      pend_fin = pend_ff;
      if (fin_word && fin_idx < 5'(acl_pkg::NUM_FIELDS)) begin
         pend_fin[fin_idx[3:0]] = fin_ok ? num_val : 16'h0000;
      end
      fv_fin = fv_ff && !(fin_word && !fin_ok);
   end

   assign info.word_count = wc_ff;
   assign info.keyword    = kw_ff;
   assign info.fields_ok  = fv_fin;
   assign fields          = pend_fin;

   always_comb begin
      len_inc  = {1'b0, len_ff} + (LW+1)'(1);
      is_digit = (rx_byte >= acl_pkg::CH_ZERO) && (rx_byte <= acl_pkg::CH_NINE);
      is_space = (rx_byte == acl_pkg::CH_SPACE) ||
                 (rx_byte >= acl_pkg::CH_TAB && rx_byte <= acl_pkg::CH_CR);
      wc_new   = wc_ff;
      ph       = ph_ff;
      acc      = acc_ff;
      neg      = neg_ff;
      ovf      = ovf_ff;
      nv       = '0;
      len_in   = len_ff;
      wc_in    = wc_ff;
      inw_in   = inw_ff;
      nul_in   = nul_ff;
      kw_in    = kw_ff;
      ph_in    = ph_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      fv_in    = fv_ff;
      pend_in  = pend_ff;
      if (rx_byte == acl_pkg::CH_LF || (rx_byte != acl_pkg::CH_CR && len_inc >= LEN_LIMIT))
      begin
         len_in = '0;
         wc_in  = '0;
         inw_in = 1'b0;
         nul_in = 1'b0;
         kw_in  = acl_pkg::KW_ROOT;
         ph_in  = PH_WS;
         acc_in = '0;
         neg_in = 1'b0;
         ovf_in = 1'b0;
         fv_in  = 1'b1;
         if (rx_byte == acl_pkg::CH_LF) begin
            pend_in = pend_fin;
         end
      end else if (rx_byte != acl_pkg::CH_CR) begin
         len_in = len_inc[LW-1:0];
         if (!nul_ff) begin
            if (rx_byte == acl_pkg::CH_NUL || rx_byte == acl_pkg::CH_COMMA) begin
               nul_in  = (rx_byte == acl_pkg::CH_NUL);
               inw_in  = 1'b0;
               fv_in   = fv_fin;
               pend_in = pend_fin;
            end else begin
               if (!inw_ff) begin
                  wc_new = (wc_ff == acl_pkg::WC_MAX) ? wc_ff : wc_ff + 5'd1;
                  ph     = PH_WS;
                  acc    = '0;
                  neg    = 1'b0;
                  ovf    = 1'b0;
               end
               if (wc_new == 5'd1) begin
                  kw_in = acl_pkg::kw_next(kw_ff, rx_byte);
               end else if (ph == PH_WS && is_space) begin
                  ph = PH_WS;
               end else if (ph == PH_WS &&
                            (rx_byte == acl_pkg::CH_PLUS || rx_byte == acl_pkg::CH_MINUS)) begin
                  neg = (rx_byte == acl_pkg::CH_MINUS);
                  ph  = PH_SIGN;
               end else if (ph == PH_BAD) begin
                  ph = PH_BAD;
               end else if (!is_digit) begin
                  ph = PH_BAD;
               end else begin
                  ph = PH_DIGITS;
                  if (!ovf) begin
                     nv = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                        + {32'd0, 4'(rx_byte - acl_pkg::CH_ZERO)};
                     if (nv > 36'h0_8000_0000) begin
                        ovf = 1'b1;
                     end else begin
                        acc = nv[31:0];
                     end
                  end
               end
               wc_in  = wc_new;
               inw_in = 1'b1;
               ph_in  = ph;
               acc_in = acc;
               neg_in = neg;
               ovf_in = ovf;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         wc_ff  <= '0;
         inw_ff <= 1'b0;
         nul_ff <= 1'b0;
         kw_ff  <= acl_pkg::KW_ROOT;
         ph_ff  <= PH_WS;
         acc_ff <= '0;
         neg_ff <= 1'b0;
         ovf_ff <= 1'b0;
         fv_ff  <= 1'b1;
      end else if (step) begin
         len_ff <= len_in;
         wc_ff  <= wc_in;
         inw_ff <= inw_in;
         nul_ff <= nul_in;
         kw_ff  <= kw_in;
         ph_ff  <= ph_in;
         acc_ff <= acc_in;
         neg_ff <= neg_in;
         ovf_ff <= ovf_in;
         fv_ff  <= fv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         pend_ff <= pend_in;
      end
   end

endmodule

FILE: rtl/core/acl_commit.sv
// ----------------------------------------------------------------------------
// acl_commit
// Judges a finished line and updates the committed registers.
// ----------------------------------------------------------------------------
module acl_commit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     commit,
   input  acl_pkg::line_info_type   info,
   input  acl_pkg::field_array_type fields,
   output acl_pkg::result_type      result
);

   localparam int NUM_F = acl_pkg::NUM_FIELDS;

   acl_pkg::value_array_type vals_ff, vals_in;
   logic [5:0]               btn_ff, btn_in;
   logic                     run_ff, run_in;
   logic [31:0]              err_ff, err_in;

   acl_pkg::cmd_type cmd;
   logic             acc;
   logic [NUM_F-1:0] flag;
   logic [15:0]      code;
   logic [31:0]      weight;

   always_comb begin
      for (int i = 0; i < NUM_F; i++) begin
         flag[i] = (fields[i] != 16'h0000);
      end
      code   = fields[0];
      weight = (code[3] ? 32'd1000000 : 32'd0) + (code[2] ? 32'd10000 : 32'd0)
             + (code[1] ? 32'd100 : 32'd0) + {31'd0, code[0]};
      cmd     = (info.word_count == 5'd0) ? acl_pkg::CMD_EMPTY : acl_pkg::kw_term(info.keyword);
      acc     = 1'b0;
      vals_in = vals_ff;
      btn_in  = btn_ff;
      run_in  = run_ff;
      err_in  = err_ff;
      case (cmd)
         acl_pkg::CMD_DAT: begin
            if (info.word_count == 5'd13 && info.fields_ok) begin
               acc        = 1'b1;
               btn_in     = {flag[0], flag[6], flag[7], flag[8], flag[9], flag[10]};
               vals_in[0] = fields[1];
               vals_in[1] = fields[2];
               vals_in[2] = fields[3];
               vals_in[3] = fields[4];
               vals_in[4] = fields[5];
               vals_in[5] = fields[11];
            end
         end
         acl_pkg::CMD_D: begin
            if (info.word_count == 5'd8 && info.fields_ok) begin
               acc        = 1'b1;
               btn_in     = {flag[0], flag[2], flag[3], flag[4], flag[5], flag[6]};
               vals_in[0] = fields[1];
            end
         end
         acl_pkg::CMD_DLOW: begin
            if (info.word_count == 5'd3 && info.fields_ok) begin
               acc        = 1'b1;
               btn_in     = code[5:0];
               vals_in[0] = fields[1];
            end
         end
         acl_pkg::CMD_START: begin
            acc    = 1'b1;
            run_in = 1'b1;
         end
         acl_pkg::CMD_STOP: begin
            acc    = 1'b1;
            run_in = 1'b0;
         end
         acl_pkg::CMD_MOT: begin
            if (info.word_count == 5'd4 && info.fields_ok) begin
               acc        = 1'b1;
               vals_in[2] = fields[0];
               vals_in[3] = fields[1];
               vals_in[4] = fields[2];
            end
         end
         acl_pkg::CMD_R, acl_pkg::CMD_C, acl_pkg::CMD_L,
         acl_pkg::CMD_THRESH, acl_pkg::CMD_SENSI, acl_pkg::CMD_E: begin
            if (info.word_count == 5'd2 && info.fields_ok) begin
               acc = 1'b1;
               case (cmd)
                  acl_pkg::CMD_R:      vals_in[2] = code;
                  acl_pkg::CMD_C:      vals_in[3] = code;
                  acl_pkg::CMD_L:      vals_in[4] = code;
                  acl_pkg::CMD_THRESH: vals_in[1] = code;
                  acl_pkg::CMD_SENSI:  vals_in[6] = code;
                  default:             err_in = err_ff + weight;
               endcase
            end
         end
         default: acc = 1'b0;
      endcase
   end

   assign result.command     = cmd;
   assign result.accepted    = acc;
   assign result.buttons     = btn_in;
   assign result.values      = vals_in;
   assign result.running     = run_in;
   assign result.link_errors = err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vals_ff <= '0;
         btn_ff  <= '0;
         run_ff  <= 1'b0;
         err_ff  <= '0;
      end else if (commit) begin
         vals_ff <= vals_in;
         btn_ff  <= btn_in;
         run_ff  <= run_in;
         err_ff  <= err_in;
      end
   end

endmodule

FILE: rtl/core/ascii_command_line_parser.sv
// ----------------------------------------------------------------------------
// ascii_command_line_parser
// Byte-stream command line parser with a registered byte stage and result.
// ----------------------------------------------------------------------------
//  channel  ports  direction  transfer
//  request  req_   in         one received byte
//  response rsp_   out        one line result, per LF
//
//  One byte per cycle through the byte register; its parse and the line
//  commit are combinational between that register and the result register.
//  An LF byte waits in the byte register only while the result register is
//  full and stalled. Synchronous reset clears parse state and committed values.
// ----------------------------------------------------------------------------
module ascii_command_line_parser #(
   parameter int LINE_MAX = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_command,
   output logic               rsp_accepted,
   output logic [5:0]         rsp_buttons,
   output logic signed [15:0] rsp_capacitance,
   output logic signed [15:0] rsp_cap_threshold,
   output logic signed [15:0] rsp_motor_right,
   output logic signed [15:0] rsp_motor_center,
   output logic signed [15:0] rsp_motor_left,
   output logic signed [15:0] rsp_servo_pos,
   output logic signed [15:0] rsp_sensitivity,
   output logic               rsp_running,
   output logic [31:0]        rsp_link_errors
);

   logic [7:0]               byte_ff;
   logic                     bvld_ff, bvld_in;
   logic                     rvld_ff, rvld_in;
   acl_pkg::result_type      res_ff, res;
   acl_pkg::line_info_type   info;
   acl_pkg::field_array_type fields;
   logic                     is_lf, go;

   assign is_lf     = (byte_ff == acl_pkg::CH_LF);
   assign go        = bvld_ff && (!is_lf || !rvld_ff || rsp_ready);
   assign req_ready = !bvld_ff || go;

   acl_parse #(.LINE_MAX(LINE_MAX)) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (go),
      .rx_byte (byte_ff),
      .info    (info),
      .fields  (fields)
   );

   acl_commit u_commit (
      .clock  (clock),
      .reset  (reset),
      .commit (go && is_lf),
      .info   (info),
      .fields (fields),
      .result (res)
   );

   always_comb begin
      bvld_in = bvld_ff;
      if (req_valid && req_ready) begin
         bvld_in = 1'b1;
      end else if (go) begin
         bvld_in = 1'b0;
      end
      rvld_in = rvld_ff;
      if (go && is_lf) begin
         rvld_in = 1'b1;
      end else if (rsp_ready) begin
         rvld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bvld_ff <= 1'b0;
         rvld_ff <= 1'b0;
      end else begin
         bvld_ff <= bvld_in;
         rvld_ff <= rvld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
      if (go && is_lf) begin
         res_ff <= res;
      end
   end

   assign rsp_valid         = rvld_ff;
   assign rsp_command       = res_ff.command;
   assign rsp_accepted      = res_ff.accepted;
   assign rsp_buttons       = res_ff.buttons;
   assign rsp_capacitance   = res_ff.values[0];
   assign rsp_cap_threshold = res_ff.values[1];
   assign rsp_motor_right   = res_ff.values[2];
   assign rsp_motor_center  = res_ff.values[3];
   assign rsp_motor_left    = res_ff.values[4];
   assign rsp_servo_pos     = res_ff.values[5];
   assign rsp_sensitivity   = res_ff.values[6];
   assign rsp_running       = res_ff.running;
   assign rsp_link_errors   = res_ff.link_errors;

endmodule

FILE: rtl/core/acl_checker.sv
// ----------------------------------------------------------------------------
// acl_checker
// Port-level checks on the parser's result channel.
// ----------------------------------------------------------------------------
module acl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_command,
   input logic        rsp_accepted,
   input logic        rsp_running
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_command))
      else $error("result dropped or changed under stall");

   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == acl_pkg::CMD_START |-> rsp_running && rsp_accepted)
      else $error("start did not set running");

   a_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == acl_pkg::CMD_STOP |-> !rsp_running && rsp_accepted)
      else $error("stop did not clear running");

   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command == acl_pkg::CMD_EMPTY || rsp_command == acl_pkg::CMD_UNKNOWN)
      |-> !rsp_accepted)
      else $error("empty or unknown line accepted");

endmodule

bind ascii_command_line_parser acl_checker u_acl_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_command  (rsp_command),
   .rsp_accepted (rsp_accepted),
   .rsp_running  (rsp_running)
);

FILE: test/tb_ascii_command_line_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ascii_command_line_parser
// Feeds byte streams of command lines (well-formed, broken, long, NUL, noise)
// into the parser under randomized sender gaps and receiver stalls, predicts
// each line result and compares every field of every result transfer.
// ----------------------------------------------------------------------------
module tb_ascii_command_line_parser;

   localparam int LINE_LIMIT = 128;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PH_WS = 0, PH_SIGN = 1, PH_DIGITS = 2, PH_BAD = 3;

   typedef struct packed {
      logic [3:0]  command;
      logic        accepted;
      logic [5:0]  buttons;
      logic [6:0][15:0] values;
      logic        running;
      logic [31:0] link_errors;
   } line_result_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [7:0] req_rx_byte;
   logic rsp_valid, rsp_ready;
   logic [3:0] rsp_command;
   logic rsp_accepted;
   logic [5:0] rsp_buttons;
   logic signed [15:0] rsp_capacitance, rsp_cap_threshold, rsp_motor_right;
   logic signed [15:0] rsp_motor_center, rsp_motor_left, rsp_servo_pos, rsp_sensitivity;
   logic rsp_running;
   logic [31:0] rsp_link_errors;

   ascii_command_line_parser #(.LINE_MAX(LINE_LIMIT)) dut (.*);

   // predictor state
   int          p_len, p_words, p_phase;
   bit          p_in_word, p_nul, p_neg, p_ovf, p_ok;
   logic [4:0]  p_kw;
   logic [31:0] p_acc;
   logic [15:0] p_fields[acl_pkg::NUM_FIELDS];
   logic [15:0] p_values[acl_pkg::NUM_VALUES];
   logic [5:0]  p_buttons;
   bit          p_running;
   logic [31:0] p_errors;

   logic [7:0]      byte_queue[$];
   line_result_type line_results[$];
   int   idle_pct, stall_pct, hold_cycles, quiet_cycles;
   bit   failed, stim_done;
   bit   req_ready_seen;
   line_result_type got;

   initial clock = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void restart_line();
      p_len = 0; p_words = 0; p_in_word = 0; p_nul = 0; p_kw = acl_pkg::KW_ROOT;
      p_phase = PH_WS; p_acc = 0; p_neg = 0; p_ovf = 0; p_ok = 1;
   endfunction

   function automatic logic [15:0] number_bits();
      if (p_neg) return p_ovf ? 16'h0 : 16'(32'h0 - p_acc);
      if (p_ovf || p_acc > 32'h7FFF_FFFF) return 16'hFFFF;
      return p_acc[15:0];
   endfunction

   function automatic void close_word();
      bit good;
      if (!p_in_word) return;
      p_in_word = 0;
      if (p_words < 2) return;
      good = (p_phase == PH_DIGITS);
      if (!good) p_ok = 0;
      if (p_words - 2 < acl_pkg::NUM_FIELDS)
         p_fields[p_words - 2] = good ? number_bits() : 16'h0;
   endfunction

   function automatic logic [4:0] keyword_next(logic [4:0] s, logic [7:0] c);
      case ({s, c})
         {5'd0, "D"}: return 5'd1;   {5'd1, "A"}: return 5'd2;
         {5'd2, "T"}: return 5'd3;   {5'd0, "d"}: return 5'd4;
         {5'd0, "s"}: return 5'd5;   {5'd5, "t"}: return 5'd6;
         {5'd6, "a"}: return 5'd7;   {5'd7, "r"}: return 5'd8;
         {5'd8, "t"}: return 5'd9;   {5'd6, "o"}: return 5'd10;
         {5'd10, "p"}: return 5'd11; {5'd0, "M"}: return 5'd12;
         {5'd12, "O"}: return 5'd13; {5'd13, "T"}: return 5'd14;
         {5'd0, "R"}: return 5'd15;  {5'd0, "C"}: return 5'd16;
         {5'd0, "L"}: return 5'd17;  {5'd0, "T"}: return 5'd18;
         {5'd18, "H"}: return 5'd19; {5'd19, "R"}: return 5'd20;
         {5'd20, "E"}: return 5'd21; {5'd21, "S"}: return 5'd22;
         {5'd22, "H"}: return 5'd23; {5'd0, "S"}: return 5'd24;
         {5'd24, "E"}: return 5'd25; {5'd25, "N"}: return 5'd26;
         {5'd26, "S"}: return 5'd27; {5'd27, "I"}: return 5'd28;
         {5'd0, "E"}: return 5'd29;
         default: return acl_pkg::KW_DEAD;
      endcase
   endfunction

   function automatic acl_pkg::cmd_type keyword_command(logic [4:0] s);
      case (s)
         5'd1: return acl_pkg::CMD_D;       5'd3: return acl_pkg::CMD_DAT;
         5'd4: return acl_pkg::CMD_DLOW;    5'd9: return acl_pkg::CMD_START;
         5'd11: return acl_pkg::CMD_STOP;   5'd14: return acl_pkg::CMD_MOT;
         5'd15: return acl_pkg::CMD_R;      5'd16: return acl_pkg::CMD_C;
         5'd17: return acl_pkg::CMD_L;      5'd23: return acl_pkg::CMD_THRESH;
         5'd28: return acl_pkg::CMD_SENSI;  5'd29: return acl_pkg::CMD_E;
         default: return acl_pkg::CMD_UNKNOWN;
      endcase
   endfunction

   function automatic void feed_number(logic [7:0] c);
      bit digit, space;
      logic [63:0] nv;
      digit = (c >= acl_pkg::CH_ZERO && c <= acl_pkg::CH_NINE);
      space = (c == acl_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13));
      if (p_phase == PH_WS) begin
         if (space) return;
         if (c == acl_pkg::CH_PLUS || c == acl_pkg::CH_MINUS) begin
            p_neg = (c == acl_pkg::CH_MINUS);
            p_phase = PH_SIGN;
            return;
         end
      end
      if (p_phase == PH_BAD) return;
      if (!digit) begin
         p_phase = PH_BAD;
         return;
      end
      p_phase = PH_DIGITS;
      if (!p_ovf) begin
         nv = 64'(p_acc) * 10 + 64'(c - acl_pkg::CH_ZERO);
         if (nv > 64'd2147483648) p_ovf = 1;
         else p_acc = nv[31:0];
      end
   endfunction

   function automatic logic [4:0] switch_bits(int first);
      logic [4:0] b;
      b = 0;
      for (int k = 0; k < 5; k++) if (p_fields[first + k] != 0) b[4 - k] = 1'b1;
      return b;
   endfunction

   function automatic bit commit_line(acl_pkg::cmd_type cmd);
      logic [15:0] code;
      case (cmd)
         acl_pkg::CMD_DAT: begin
            if (p_words != 13 || !p_ok) return 0;
            p_buttons = {p_fields[0] != 0, switch_bits(6)};
            for (int i = 0; i < 5; i++) p_values[i] = p_fields[i + 1];
            p_values[5] = p_fields[11];
            return 1;
         end
         acl_pkg::CMD_D: begin
            if (p_words != 8 || !p_ok) return 0;
            p_buttons = {p_fields[0] != 0, switch_bits(2)};
            p_values[0] = p_fields[1];
            return 1;
         end
         acl_pkg::CMD_DLOW: begin
            if (p_words != 3 || !p_ok) return 0;
            p_buttons = p_fields[0][5:0];
            p_values[0] = p_fields[1];
            return 1;
         end
         acl_pkg::CMD_START: begin
            p_running = 1;
            return 1;
         end
         acl_pkg::CMD_STOP: begin
            p_running = 0;
            return 1;
         end
         acl_pkg::CMD_MOT: begin
            if (p_words != 4 || !p_ok) return 0;
            for (int i = 0; i < 3; i++) p_values[i + 2] = p_fields[i];
            return 1;
         end
         acl_pkg::CMD_R, acl_pkg::CMD_C, acl_pkg::CMD_L, acl_pkg::CMD_THRESH,
         acl_pkg::CMD_SENSI, acl_pkg::CMD_E: begin
            if (p_words != 2 || !p_ok) return 0;
            code = p_fields[0];
            case (cmd)
               acl_pkg::CMD_R: p_values[2] = code;
               acl_pkg::CMD_C: p_values[3] = code;
               acl_pkg::CMD_L: p_values[4] = code;
               acl_pkg::CMD_THRESH: p_values[1] = code;
               acl_pkg::CMD_SENSI: p_values[6] = code;
               default: p_errors += code[3] * 32'd1000000 + code[2] * 32'd10000
                                  + code[1] * 32'd100 + code[0];
            endcase
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   function automatic void predict_byte(logic [7:0] c);
      acl_pkg::cmd_type cmd;
      line_result_type r;
      if (c == acl_pkg::CH_CR) return;
      if (c != acl_pkg::CH_LF) begin
         p_len++;
         if (p_len >= LINE_LIMIT - 1) begin
            restart_line();
            return;
         end
         if (p_nul) return;
         if (c == acl_pkg::CH_NUL) begin
            p_nul = 1;
            close_word();
            return;
         end
         if (c == acl_pkg::CH_COMMA) begin
            close_word();
            return;
         end
         if (!p_in_word) begin
            p_in_word = 1;
            if (p_words < 31) p_words++;
            p_phase = PH_WS; p_acc = 0; p_neg = 0; p_ovf = 0;
         end
         if (p_words == 1) p_kw = keyword_next(p_kw, c);
         else feed_number(c);
         return;
      end
      close_word();
      cmd = (p_words == 0) ? acl_pkg::CMD_EMPTY : keyword_command(p_kw);
      r.accepted = commit_line(cmd);
      r.command = cmd;
      r.buttons = p_buttons;
      for (int i = 0; i < acl_pkg::NUM_VALUES; i++) r.values[i] = p_values[i];
      r.running = p_running;
      r.link_errors = p_errors;
      line_results.push_back(r);
      restart_line();
   endfunction

   // stimulus builders
   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
   endfunction

   function automatic string random_number();
      string s;
      int kind;
      s = "";
      if ($urandom_range(0, 5) == 0) s = {s, " "};
      if ($urandom_range(0, 3) == 0) s = {s, ($urandom_range(0, 1) ? "-" : "+")};
      kind = $urandom_range(0, 9);
      if (kind == 0) s = {s, "99999999999"};
      else if (kind == 1) s = {s, $sformatf("%0d", $urandom_range(0, 65535))};
      else if (kind < 6) s = {s, $sformatf("%0d", $urandom_range(0, 1))};
      else s = {s, $sformatf("%0d", $urandom_range(0, 20))};
      if ($urandom_range(0, 30) == 0) s = {s, "x"};
      return s;
   endfunction

   function automatic void push_random_line();
      string kws[14] = '{"DAT", "D", "d", "start", "stop", "MOT", "R", "C", "L",
                         "THRESH", "SENSI", "E", "Q", ""};
      int nwords[14] = '{13, 8, 3, 1, 1, 4, 2, 2, 2, 2, 2, 2, 2, 0};
      int k, n, sel;
      string s;
      sel = $urandom_range(0, 19);
      if (sel >= 18) begin
         // noise line: any byte, rarely an early LF
         n = $urandom_range(1, 20);
         for (int i = 0; i < n; i++) byte_queue.push_back(8'($urandom_range(0, 255)));
         byte_queue.push_back(acl_pkg::CH_LF);
         return;
      end
      k = $urandom_range(0, 13);
      n = nwords[k];
      if ($urandom_range(0, 7) == 0) n = n + $urandom_range(0, 2) - 1;
      s = kws[k];
      for (int i = 1; i < n; i++) begin
         s = {s, ","};
         if ($urandom_range(0, 15) == 0) s = {s, ","};
         s = {s, random_number()};
      end
      if ($urandom_range(0, 15) == 0) s = {s, ","};
      if ($urandom_range(0, 10) == 0) s = {s, "\r"};
      push_text(s);
      byte_queue.push_back(acl_pkg::CH_LF);
   endfunction

   initial begin
      push_text("\n");
      push_text("DAT,1,-32768,32767,5,6,7,1,0,1,0,1,-1\n");
      push_text("D,0,99999999999,1,1,0,0,1\n");
      push_text("d,-1,-99999999999\n");
      push_text("start,x\nstop\nMOT,+1, 2,\t-3\nR,2147483648\nC,-2147483648\n");
      push_text("L,,4,\nTHRESH,7\nSENSI,-7\nE,15\nE,-1\nfoo,1\nR,1a\nR,-\nR,1,2\n");
      byte_queue.push_back(8'hFF);
      byte_queue.push_back(8'h80);
      push_text("\nR,5");
      byte_queue.push_back(acl_pkg::CH_NUL);
      push_text("junk,9\n");
      for (int i = 0; i < 140; i++) byte_queue.push_back(i[0] ? "1" : ",");
      push_text("\nR,8\n");
      while (byte_queue.size() < 1050) push_random_line();
   end

   initial begin
      failed = 0; stim_done = 0;
      idle_pct = 0; stall_pct = 0; hold_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'h00;
      rsp_ready = 1'b0;
      restart_line();
      for (int i = 0; i < acl_pkg::NUM_FIELDS; i++) p_fields[i] = 0;
      for (int i = 0; i < acl_pkg::NUM_VALUES; i++) p_values[i] = 0;
      p_buttons = 0; p_running = 0; p_errors = 0;
      repeat (9) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      repeat (250) @(posedge clock);
      idle_pct = 64;
      repeat (250) @(posedge clock);
      idle_pct = 0; stall_pct = 64;
      repeat (250) @(posedge clock);
      idle_pct = 21; stall_pct = 21;
      repeat (200) @(posedge clock);
      idle_pct = 0; stall_pct = 0; hold_cycles = 300;
      repeat (400) @(posedge clock);
      idle_pct = 21; stall_pct = 64;
      wait (byte_queue.size() == 0 && !req_valid);
      stim_done = 1;
      wait (line_results.size() == 0);
      repeat (20) @(posedge clock);
      if (!failed && line_results.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready_seen) begin
            if (byte_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_rx_byte <= byte_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // monitor
   initial req_ready_seen = 0;
   always @(posedge clock) begin
      req_ready_seen <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (req_valid && req_ready) predict_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            got.command = rsp_command;
            got.accepted = rsp_accepted;
            got.buttons = rsp_buttons;
            got.values = {rsp_sensitivity, rsp_servo_pos, rsp_motor_left,
                          rsp_motor_center, rsp_motor_right, rsp_cap_threshold,
                          rsp_capacitance};
            got.running = rsp_running;
            got.link_errors = rsp_link_errors;
            if (line_results.size() == 0) begin
               $display("%0t unexpected result transfer, actual %h", $time, got);
               failed <= 1;
            end else begin
               if (got !== line_results[0]) begin
                  $display("%0t result mismatch: expected %h actual %h",
                           $time, line_results[0], got);
                  failed <= 1;
               end
               void'(line_results.pop_front());
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end else begin
         quiet_cycles <= 0;
      end
   end

endmodule
